### rtl/h3fo_pkg.sv
// Shared codes for the HTTP/3 message frame order checker.
package h3fo_pkg;

  localparam int unsigned PhaseW = 5;
  localparam int unsigned EventW = 3;
  localparam int unsigned RoleW  = 2;
  localparam int unsigned StatW  = 2;

  typedef enum logic [StatW-1:0] {
    ST_OK         = 2'd0,
    ST_INTERNAL   = 2'd1,
    ST_UNEXPECTED = 2'd2,
    ST_PROTOCOL   = 2'd3
  } status_e;

  localparam logic [RoleW-1:0] ROLE_NONE = 2'd0;
  localparam logic [RoleW-1:0] ROLE_REQ  = 2'd1;
  localparam logic [RoleW-1:0] ROLE_RSP  = 2'd2;

  localparam logic [EventW-1:0] EV_HDR_BEGIN  = 3'd0;
  localparam logic [EventW-1:0] EV_HDR_END    = 3'd1;
  localparam logic [EventW-1:0] EV_PRI_BEGIN  = 3'd2;
  localparam logic [EventW-1:0] EV_PRI_END    = 3'd3;
  localparam logic [EventW-1:0] EV_DATA_BEGIN = 3'd4;
  localparam logic [EventW-1:0] EV_DATA_END   = 3'd5;
  localparam logic [EventW-1:0] EV_MSG_END    = 3'd6;

  localparam logic [PhaseW-1:0] PH_NONE       = 5'd0;
  localparam logic [PhaseW-1:0] PH_REQ_INIT   = 5'd1;
  localparam logic [PhaseW-1:0] PH_REQ_PRI_B  = 5'd2;
  localparam logic [PhaseW-1:0] PH_REQ_PRI_E  = 5'd3;
  localparam logic [PhaseW-1:0] PH_REQ_HDR_B  = 5'd4;
  localparam logic [PhaseW-1:0] PH_REQ_HDR_E  = 5'd5;
  localparam logic [PhaseW-1:0] PH_REQ_DATA_B = 5'd6;
  localparam logic [PhaseW-1:0] PH_REQ_DATA_E = 5'd7;
  localparam logic [PhaseW-1:0] PH_REQ_TRL_B  = 5'd8;
  localparam logic [PhaseW-1:0] PH_REQ_TRL_E  = 5'd9;
  localparam logic [PhaseW-1:0] PH_REQ_END    = 5'd10;
  localparam logic [PhaseW-1:0] PH_RSP_INIT   = 5'd11;
  localparam logic [PhaseW-1:0] PH_RSP_HDR_B  = 5'd12;
  localparam logic [PhaseW-1:0] PH_RSP_HDR_E  = 5'd13;
  localparam logic [PhaseW-1:0] PH_RSP_DATA_B = 5'd14;
  localparam logic [PhaseW-1:0] PH_RSP_DATA_E = 5'd15;
  localparam logic [PhaseW-1:0] PH_RSP_TRL_B  = 5'd16;
  localparam logic [PhaseW-1:0] PH_RSP_TRL_E  = 5'd17;
  localparam logic [PhaseW-1:0] PH_RSP_END    = 5'd18;

  typedef struct packed {
    status_e             status;
    logic [PhaseW-1:0]   phase;
    logic                empty_headers_ok;
  } step_res_t;

endpackage

### rtl/h3fo_step.sv
// Phase transition logic for one item: next phase, status and empty-headers flag.
module h3fo_step (
  input  logic [h3fo_pkg::PhaseW-1:0] phase_i,
  input  logic [h3fo_pkg::RoleW-1:0]  role_i,
  input  logic                        kind_i,
  input  logic [h3fo_pkg::EventW-1:0] event_i,
  output h3fo_pkg::step_res_t         res_o
);

  logic [h3fo_pkg::PhaseW-1:0] nxt;
  h3fo_pkg::status_e           st;

  always_comb begin
    nxt = phase_i;
    st  = h3fo_pkg::ST_OK;
    if (kind_i) begin
      // restart at the role's initial phase
      case (role_i)
        h3fo_pkg::ROLE_REQ: nxt = h3fo_pkg::PH_REQ_INIT;
        h3fo_pkg::ROLE_RSP: nxt = h3fo_pkg::PH_RSP_INIT;
        default:            nxt = h3fo_pkg::PH_NONE;
      endcase
    end else begin
      case (phase_i)
        h3fo_pkg::PH_REQ_INIT: begin
          if (event_i == h3fo_pkg::EV_HDR_BEGIN) nxt = h3fo_pkg::PH_REQ_HDR_B;
          else if (event_i == h3fo_pkg::EV_PRI_BEGIN) nxt = h3fo_pkg::PH_REQ_PRI_B;
          else st = h3fo_pkg::ST_UNEXPECTED;
        end
        h3fo_pkg::PH_REQ_PRI_B: begin
          if (event_i == h3fo_pkg::EV_PRI_END) nxt = h3fo_pkg::PH_REQ_PRI_E;
          else st = h3fo_pkg::ST_PROTOCOL;
        end
        h3fo_pkg::PH_REQ_PRI_E: begin
          if (event_i == h3fo_pkg::EV_HDR_BEGIN) nxt = h3fo_pkg::PH_REQ_HDR_B;
          else st = h3fo_pkg::ST_UNEXPECTED;
        end
        h3fo_pkg::PH_REQ_HDR_B: begin
          if (event_i == h3fo_pkg::EV_HDR_END) nxt = h3fo_pkg::PH_REQ_HDR_E;
          else st = h3fo_pkg::ST_PROTOCOL;
        end
        h3fo_pkg::PH_REQ_HDR_E: begin
          if (event_i == h3fo_pkg::EV_DATA_BEGIN) nxt = h3fo_pkg::PH_REQ_DATA_B;
          else if (event_i == h3fo_pkg::EV_MSG_END) nxt = h3fo_pkg::PH_REQ_END;
          else st = h3fo_pkg::ST_UNEXPECTED;
        end
        h3fo_pkg::PH_REQ_DATA_B: begin
          if (event_i == h3fo_pkg::EV_DATA_END) nxt = h3fo_pkg::PH_REQ_DATA_E;
          else st = h3fo_pkg::ST_PROTOCOL;
        end
        h3fo_pkg::PH_REQ_DATA_E: begin
          if (event_i == h3fo_pkg::EV_DATA_BEGIN) nxt = h3fo_pkg::PH_REQ_DATA_B;
          else if (event_i == h3fo_pkg::EV_HDR_BEGIN) nxt = h3fo_pkg::PH_REQ_TRL_B;
          else if (event_i == h3fo_pkg::EV_MSG_END) nxt = h3fo_pkg::PH_REQ_END;
          else st = h3fo_pkg::ST_UNEXPECTED;
        end
        h3fo_pkg::PH_REQ_TRL_B: begin
          if (event_i == h3fo_pkg::EV_HDR_END) nxt = h3fo_pkg::PH_REQ_TRL_E;
          else st = h3fo_pkg::ST_PROTOCOL;
        end
        h3fo_pkg::PH_REQ_TRL_E: begin
          if (event_i == h3fo_pkg::EV_MSG_END) nxt = h3fo_pkg::PH_REQ_END;
          else st = h3fo_pkg::ST_UNEXPECTED;
        end
        h3fo_pkg::PH_REQ_END: st = h3fo_pkg::ST_PROTOCOL;
        h3fo_pkg::PH_RSP_INIT: begin
          if (event_i == h3fo_pkg::EV_HDR_BEGIN) nxt = h3fo_pkg::PH_RSP_HDR_B;
          else st = h3fo_pkg::ST_UNEXPECTED;
        end
        h3fo_pkg::PH_RSP_HDR_B: begin
          if (event_i == h3fo_pkg::EV_HDR_END) nxt = h3fo_pkg::PH_RSP_HDR_E;
          else st = h3fo_pkg::ST_PROTOCOL;
        end
        h3fo_pkg::PH_RSP_HDR_E: begin
          if (event_i == h3fo_pkg::EV_DATA_BEGIN) nxt = h3fo_pkg::PH_RSP_DATA_B;
          else if (event_i == h3fo_pkg::EV_MSG_END) nxt = h3fo_pkg::PH_RSP_END;
          else st = h3fo_pkg::ST_UNEXPECTED;
        end
        h3fo_pkg::PH_RSP_DATA_B: begin
          if (event_i == h3fo_pkg::EV_DATA_END) nxt = h3fo_pkg::PH_RSP_DATA_E;
          else st = h3fo_pkg::ST_PROTOCOL;
        end
        h3fo_pkg::PH_RSP_DATA_E: begin
          if (event_i == h3fo_pkg::EV_DATA_BEGIN) nxt = h3fo_pkg::PH_RSP_DATA_B;
          else if (event_i == h3fo_pkg::EV_HDR_BEGIN) nxt = h3fo_pkg::PH_RSP_TRL_B;
          else if (event_i == h3fo_pkg::EV_MSG_END) nxt = h3fo_pkg::PH_RSP_END;
          else st = h3fo_pkg::ST_UNEXPECTED;
        end
        h3fo_pkg::PH_RSP_TRL_B: begin
          if (event_i == h3fo_pkg::EV_HDR_END) nxt = h3fo_pkg::PH_RSP_TRL_E;
          else st = h3fo_pkg::ST_PROTOCOL;
        end
        h3fo_pkg::PH_RSP_TRL_E: begin
          if (event_i == h3fo_pkg::EV_MSG_END) nxt = h3fo_pkg::PH_RSP_END;
          else st = h3fo_pkg::ST_UNEXPECTED;
        end
        h3fo_pkg::PH_RSP_END: st = h3fo_pkg::ST_PROTOCOL;
        // phase none and unreachable codes
        default: st = h3fo_pkg::ST_INTERNAL;
      endcase
    end
  end

  always_comb begin
    res_o.status           = st;
    res_o.phase            = nxt;
    res_o.empty_headers_ok = (nxt inside {h3fo_pkg::PH_REQ_TRL_B, h3fo_pkg::PH_RSP_TRL_B});
  end

endmodule

### rtl/http3_message_frame_order_checker.sv
// Top level of the HTTP/3 message frame order checker: input stage, phase register, result stage.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------------------
//   in      | in        | in_valid_i / in_stall_o   | kind_i, event_req_i
//   out     | out       | out_valid_o / out_stall_i | status_o, phase_o, empty_headers_ok_o
//   cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_role_i
//
// One item per cycle sustained while the output is not stalled; an item is first taken into
// the input register, then the phase update and the result register take it at the same edge.
// Reset clears role, phase and both stage valid bits; no clearing pass.
// A stall on the output holds both stages; in_stall_o follows from that within the cycle.
module http3_message_frame_order_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [h3fo_pkg::RoleW-1:0]  cfg_role_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [h3fo_pkg::EventW-1:0] event_req_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [h3fo_pkg::StatW-1:0]  status_o,
  output logic [h3fo_pkg::PhaseW-1:0] phase_o,
  output logic                        empty_headers_ok_o
);

  logic [h3fo_pkg::RoleW-1:0]  role_q;
  logic [h3fo_pkg::PhaseW-1:0] phase_q;
  logic                        in_vld_q;
  logic                        kind_q;
  logic [h3fo_pkg::EventW-1:0] event_q;
  logic                        out_vld_q;
  h3fo_pkg::status_e           status_q;
  logic                        ehok_q;
  logic                        out_free;
  logic                        step_go;
  logic                        in_xfer;
  h3fo_pkg::step_res_t         step_res;

  assign cfg_ready_o = 1'b1;

  assign out_free = !out_vld_q || !out_stall_i;
  assign step_go  = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_xfer  = in_valid_i && !in_stall_o;

  h3fo_step u_step (
    .phase_i (phase_q),
    .role_i  (role_q),
    .kind_i  (kind_q),
    .event_i (event_q),
    .res_o   (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q    <= h3fo_pkg::ROLE_NONE;
      phase_q   <= h3fo_pkg::PH_NONE;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) role_q <= cfg_role_i;
      if (!in_vld_q || step_go) in_vld_q <= in_valid_i;
      if (out_free) out_vld_q <= in_vld_q;
      if (step_go) phase_q <= step_res.phase;
    end
  end

  // payload registers: capture on transfer, hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q  <= kind_i;
      event_q <= event_req_i;
    end
    if (step_go) begin
      status_q <= step_res.status;
      ehok_q   <= step_res.empty_headers_ok;
    end
  end

  // phase_q only moves together with the result register, so it is the result's phase
  assign out_valid_o        = out_vld_q;
  assign status_o           = status_q;
  assign phase_o            = phase_q;
  assign empty_headers_ok_o = ehok_q;

endmodule

### rtl/h3fo_checker.sv
// Port-level assertions for the HTTP/3 message frame order checker, with bind.
module h3fo_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [h3fo_pkg::StatW-1:0]  status_o,
  input logic [h3fo_pkg::PhaseW-1:0] phase_o,
  input logic                        empty_headers_ok_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(phase_o) && $stable(status_o))
    else $error("stalled result changed");

  a_ehok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> empty_headers_ok_o ==
      (phase_o == h3fo_pkg::PH_REQ_TRL_B || phase_o == h3fo_pkg::PH_RSP_TRL_B))
    else $error("empty headers flag does not match phase");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> phase_o <= h3fo_pkg::PH_RSP_END)
    else $error("phase out of range");

  a_internal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == h3fo_pkg::ST_INTERNAL |-> phase_o == h3fo_pkg::PH_NONE)
    else $error("internal error outside phase none");

endmodule

bind http3_message_frame_order_checker h3fo_checker u_h3fo_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .status_o           (status_o),
  .phase_o            (phase_o),
  .empty_headers_ok_o (empty_headers_ok_o)
);
